### rtl/core/ps2mt_pkg.sv
package ps2mt_pkg;

  // field and register widths
  localparam int CoordBitsDef = 13;
  localparam int SizeW        = 13;
  localparam int ByteW        = 8;
  localparam int DeltaW       = ByteW + 1;
  localparam int CfgIdxW      = 2;
  localparam int CntW         = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = CfgIdxW'(1);

  // packet header bits
  localparam logic [ByteW-1:0] SyncMask = 8'h08;
  localparam logic [ByteW-1:0] OvfMask  = 8'hC0;
  localparam logic [ByteW-1:0] LeftMask = 8'h01;
  localparam int               PktLen   = 3;

  // reset values
  localparam int ResetWidth  = 640;
  localparam int ResetHeight = 480;
  localparam int ResetX      = 320;
  localparam int ResetY      = 240;

  // one decoded packet, valid in the cycle its last byte is consumed
  typedef struct packed {
    logic                     done;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic                     left;
  } pkt_t;

endpackage

### rtl/core/ps2mt_if.sv
interface ps2mt_byte_if import ps2mt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface ps2mt_cfg_if import ps2mt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [SizeW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface ps2mt_pos_if import ps2mt_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_position;
  logic [COORD_BITS-1:0] y_position;
  logic                  left_button;
  logic                  left_click;

  modport source (output valid, output x_position, output y_position, output left_button,
                  output left_click, input ready);
  modport sink (input valid, input x_position, input y_position, input left_button,
                input left_click, output ready);
endinterface

### rtl/core/ps2mt_framer.sv
module ps2mt_framer import ps2mt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output pkt_t             pkt_o
);

  localparam logic [CntW-1:0] CntIdle = CntW'(0);
  localparam logic [CntW-1:0] CntHdr  = CntW'(1);
  localparam logic [CntW-1:0] CntLast = CntW'(PktLen - 1);

  logic [CntW-1:0]  count_q, count_d;
  logic [ByteW-1:0] hdr_q, hdr_d;
  logic [ByteW-1:0] dx_q, dx_d;

  always_comb begin
    count_d = count_q;
    hdr_d   = hdr_q;
    dx_d    = dx_q;
    if (step_i) begin
      unique case (count_q)
        CntIdle: begin
          // resync: only a byte with the sync bit may open a packet
          if ((byte_i & SyncMask) != '0) begin
            hdr_d   = byte_i;
            count_d = CntHdr;
          end
        end
        CntHdr: begin
          dx_d    = byte_i;
          count_d = CntLast;
        end
        default: begin
          count_d = CntIdle;
        end
      endcase
    end
  end

  always_comb begin
    pkt_o.done = step_i && (count_q == CntLast) && ((hdr_q & OvfMask) == '0);
    pkt_o.dx   = {dx_q[ByteW-1], dx_q};
    pkt_o.dy   = DeltaW'(0) - {byte_i[ByteW-1], byte_i};
    pkt_o.left = (hdr_q & LeftMask) != '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntIdle;
      hdr_q   <= '0;
      dx_q    <= '0;
    end else begin
      count_q <= count_d;
      hdr_q   <= hdr_d;
      dx_q    <= dx_d;
    end
  end

endmodule

### rtl/core/ps2mt_axis.sv
module ps2mt_axis import ps2mt_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int RESET_POS  = ResetX,
  parameter int RESET_SIZE = ResetWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic signed [DeltaW-1:0] delta_i,
  input  logic                     cfg_wr_i,
  input  logic [SizeW-1:0]         cfg_size_i,
  output logic [COORD_BITS-1:0]    pos_o
);

  localparam int SW = ((COORD_BITS > SizeW) ? COORD_BITS : SizeW) + 2;
  localparam logic signed [SW-1:0] MaxExt = SW'((1 << COORD_BITS) - 1);

  logic [COORD_BITS-1:0] pos_q, pos_d;
  logic [SizeW-1:0]      size_q, size_d;
  logic signed [SW-1:0]  sum, size_ext, clamped, half, centre;

  always_comb begin
    size_ext = $signed({{(SW-SizeW){1'b0}}, size_q});
    sum      = $signed({{(SW-COORD_BITS){1'b0}}, pos_q})
             + $signed({{(SW-DeltaW){delta_i[DeltaW-1]}}, delta_i});
    clamped  = sum;
    if (clamped < 0) begin
      clamped = '0;
    end
    if ((size_q != '0) && (clamped >= size_ext)) begin
      clamped = size_ext - SW'(1);
    end
    if (clamped > MaxExt) begin
      clamped = MaxExt;
    end

    // recentre on a size write, saturating at the coordinate range
    half   = $signed({{(SW-SizeW+1){1'b0}}, cfg_size_i[SizeW-1:1]});
    centre = (half > MaxExt) ? MaxExt : half;

    pos_d  = pos_q;
    size_d = size_q;
    if (cfg_wr_i) begin
      size_d = cfg_size_i;
      pos_d  = centre[COORD_BITS-1:0];
    end else if (step_i) begin
      pos_d  = clamped[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= COORD_BITS'(RESET_POS);
      size_q <= SizeW'(RESET_SIZE);
    end else begin
      pos_q  <= pos_d;
      size_q <= size_d;
    end
  end

  assign pos_o = pos_q;

endmodule

### rtl/core/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker. Raw device bytes come in on in_i, one per transaction, and are
// framed into 3-byte packets; while no packet is open a byte without the sync bit (bit 3) is
// dropped. A packet with an overflow bit set in its header is dropped silently; any other
// packet adds the signed X delta, subtracts the signed Y delta, clamps each axis to
// 0..size-1 (size 0 = no upper limit, saturate at the coordinate range) and sends one
// transaction on out_o with the new position, the left button and a left-press edge.
// Writing screen_width (index 0) or screen_height (index 1) on cfg_i sets that limit and
// recentres the axis; other indexes are ignored, and writes are only allowed while idle.
// Rate: one byte per clock cycle while out_o is not stalled. A byte waits in the input
// register, and in the cycle it moves on the framer and the two axis adders/clampers
// finish it into the pointer and output registers. Stalls on out_o back up into
// in_i only when a finished result is still waiting and the next byte is pending.
module ps2_mouse_packet_tracker import ps2mt_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ps2mt_byte_if.sink   in_i,
  ps2mt_cfg_if.sink    cfg_i,
  ps2mt_pos_if.source  out_o
);

  // input register
  logic             bvld_q, bvld_d;
  logic [ByteW-1:0] byte_q;
  logic             advance;

  // result side
  logic             ovld_q, ovld_d;
  logic             click_q, click_d;
  logic             lwd_q, lwd_d;
  pkt_t             pkt;
  logic             cfg_wr_x, cfg_wr_y;

  // the staged byte moves on whenever the result slot is free or being emptied
  assign advance    = bvld_q && (!ovld_q || out_o.ready);
  assign in_i.ready = !bvld_q || advance;

  always_comb begin
    bvld_d = bvld_q;
    if (in_i.valid && in_i.ready) begin
      bvld_d = 1'b1;
    end else if (advance) begin
      bvld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
    end
  end

  ps2mt_framer u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .pkt_o  (pkt)
  );

  // configuration is always accepted
  assign cfg_i.ready = 1'b1;
  assign cfg_wr_x    = cfg_i.valid && (cfg_i.index == CfgScreenWidth);
  assign cfg_wr_y    = cfg_i.valid && (cfg_i.index == CfgScreenHeight);

  // the pointer registers double as the result payload: they only change with a new result
  // or a size write; users must not overlap size writes with a pending result (unenforced)
  ps2mt_axis #(
    .COORD_BITS (COORD_BITS),
    .RESET_POS  (ResetX),
    .RESET_SIZE (ResetWidth)
  ) u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (pkt.done),
    .delta_i    (pkt.dx),
    .cfg_wr_i   (cfg_wr_x),
    .cfg_size_i (cfg_i.data),
    .pos_o      (out_o.x_position)
  );

  ps2mt_axis #(
    .COORD_BITS (COORD_BITS),
    .RESET_POS  (ResetY),
    .RESET_SIZE (ResetHeight)
  ) u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (pkt.done),
    .delta_i    (pkt.dy),
    .cfg_wr_i   (cfg_wr_y),
    .cfg_size_i (cfg_i.data),
    .pos_o      (out_o.y_position)
  );

  // button tracking; the last reported button state is also the one on the port
  always_comb begin
    lwd_d   = lwd_q;
    click_d = click_q;
    ovld_d  = ovld_q;
    if (pkt.done) begin
      lwd_d   = pkt.left;
      click_d = pkt.left && !lwd_q;
      ovld_d  = 1'b1;
    end else if (out_o.ready) begin
      ovld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q  <= 1'b0;
      ovld_q  <= 1'b0;
      lwd_q   <= 1'b0;
      click_q <= 1'b0;
    end else begin
      bvld_q  <= bvld_d;
      ovld_q  <= ovld_d;
      lwd_q   <= lwd_d;
      click_q <= click_d;
    end
  end

  assign out_o.valid       = ovld_q;
  assign out_o.left_button = lwd_q;
  assign out_o.left_click  = click_q;

  // a new result only appears after a completed packet went through
  a_result_from_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(advance))
    else $error("result appeared without a completed packet");

  // a stalled result must keep its position unless a size write comes in
  a_stall_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready && !cfg_i.valid |=>
      $stable(out_o.x_position) && $stable(out_o.y_position))
    else $error("pending result position changed");

  // a pending byte behind a stalled result blocks the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvld_q && out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while pipeline is full");

  // a click is only ever reported together with the button held
  a_click_needs_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.left_click |-> out_o.left_button)
    else $error("click reported with button released");

endmodule

### bench/tb_ps2_mouse_packet_tracker.sv
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_tracker;
  import ps2mt_pkg::*;

  localparam int CoordBits   = CoordBitsDef;
  localparam int CoordMax    = (1 << CoordBits) - 1;
  // cycles with no transaction on any channel before the run is declared hung
  localparam int StallLimit  = 2000;
  // settle time after the last result, with margin
  localparam int SettleCycles = 8;
  localparam int RandomBytes = 1330;

  // register indexes that map to nothing, writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgNoReg2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgNoReg3 = CfgIdxW'(3);

  typedef struct packed {
    logic [CoordBits-1:0] x_position;
    logic [CoordBits-1:0] y_position;
    logic                 left_button;
    logic                 left_click;
  } pos_t;

  logic clk_i;
  logic rst_ni;

  ps2mt_byte_if                          in_if ();
  ps2mt_cfg_if                           cfg_if ();
  ps2mt_pos_if #(.COORD_BITS(CoordBits)) pos_if ();

  ps2_mouse_packet_tracker #(
    .COORD_BITS(CoordBits)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (pos_if)
  );

  // shadow copy of the tracker: sizes, framing and pointer
  logic [SizeW-1:0]     width_q;
  logic [SizeW-1:0]     height_q;
  int                   pkt_bytes;
  logic [ByteW-1:0]     hdr_q;
  logic [ByteW-1:0]     dx_q;
  logic [CoordBits-1:0] ptr_x_q;
  logic [CoordBits-1:0] ptr_y_q;
  logic                 left_down_q;

  // positions predicted but not yet seen on the output
  pos_t expected_pos_q[$];

  int errors;
  int bytes_sent;
  int positions_checked;
  int clicks_seen;
  int reg_writes;
  int idle_cycles;

  // random gaps on the byte side and random back-pressure on the position side
  bit send_gaps;
  bit recv_stalls;

  // clamp one axis: floor at 0, below size when size is nonzero, saturate at range
  function automatic logic [CoordBits-1:0] clamp_coord(int v, logic [SizeW-1:0] size);
    int c;
    c = v;
    if (c < 0) begin
      c = 0;
    end
    if (size != 0 && c >= int'(size)) begin
      c = int'(size) - 1;
    end
    if (c > CoordMax) begin
      c = CoordMax;
    end
    return CoordBits'(c);
  endfunction

  function automatic logic [CoordBits-1:0] centre_coord(logic [SizeW-1:0] size);
    int c;
    c = int'(size) / 2;
    if (c > CoordMax) begin
      c = CoordMax;
    end
    return CoordBits'(c);
  endfunction

  // advance the shadow framer by one byte, queue a position when a packet completes
  function automatic void track_byte(logic [ByteW-1:0] b);
    pos_t p;
    if (pkt_bytes == 0) begin
      // resync: only a byte with the sync bit may open a packet
      if ((b & SyncMask) != 0) begin
        hdr_q     = b;
        pkt_bytes = 1;
      end
    end else if (pkt_bytes == 1) begin
      dx_q      = b;
      pkt_bytes = 2;
    end else begin
      pkt_bytes = 0;
      // overflow packets vanish without touching the pointer or button history
      if ((hdr_q & OvfMask) == 0) begin
        // header sign bits ignored, deltas are plain 8-bit two's complement
        ptr_x_q = clamp_coord(int'(ptr_x_q) + int'($signed(dx_q)), width_q);
        ptr_y_q = clamp_coord(int'(ptr_y_q) - int'($signed(b)), height_q);
        p.x_position  = ptr_x_q;
        p.y_position  = ptr_y_q;
        p.left_button = (hdr_q & LeftMask) != 0;
        p.left_click  = p.left_button && !left_down_q;
        left_down_q   = p.left_button;
        expected_pos_q.push_back(p);
      end
    end
  endfunction

  // a size write sets the limit and recentres that axis, framing is left alone
  function automatic void apply_reg_write(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
    case (idx)
      CfgScreenWidth: begin
        width_q = val;
        ptr_x_q = centre_coord(val);
      end
      CfgScreenHeight: begin
        height_q = val;
        ptr_y_q  = centre_coord(val);
      end
      default: ;
    endcase
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (pos_if.valid && pos_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("tb_ps2_mouse_packet_tracker: FAIL");
        $finish;
      end
    end
  end

  // position sink: draws a stall per transaction, checks each one against the oldest prediction
  initial begin : pos_sink
    pos_t got;
    pos_t want;
    int   gap;
    pos_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = recv_stalls ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        pos_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pos_if.ready <= 1'b1;
      do @(posedge clk_i); while (pos_if.valid !== 1'b1);
      got.x_position  = pos_if.x_position;
      got.y_position  = pos_if.y_position;
      got.left_button = pos_if.left_button;
      got.left_click  = pos_if.left_click;
      if (expected_pos_q.size() == 0) begin
        $error("position transaction with none expected: x=%0d y=%0d left=%0b click=%0b",
               got.x_position, got.y_position, got.left_button, got.left_click);
        errors++;
      end else begin
        want = expected_pos_q.pop_front();
        positions_checked++;
        if (got.left_click === 1'b1) begin
          clicks_seen++;
        end
        if (got.x_position !== want.x_position) begin
          $error("x_position: expected %0d, got %0d", want.x_position, got.x_position);
          errors++;
        end
        if (got.y_position !== want.y_position) begin
          $error("y_position: expected %0d, got %0d", want.y_position, got.y_position);
          errors++;
        end
        if (got.left_button !== want.left_button) begin
          $error("left_button: expected %0b, got %0b", want.left_button, got.left_button);
          errors++;
        end
        if (got.left_click !== want.left_click) begin
          $error("left_click: expected %0b, got %0b", want.left_click, got.left_click);
          errors++;
        end
      end
    end
  end

  // one byte transaction; valid stays high afterwards so back-to-back bytes need no gap
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = send_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] dx,
                             input logic [ByteW-1:0] dy);
    send_byte(hdr);
    send_byte(dx);
    send_byte(dy);
  endtask

  // stop sending and wait for every predicted position; optionally let the pipe settle
  task automatic wait_idle(input bit settle);
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_pos_q.size() != 0);
    if (settle) begin
      repeat (SettleCycles) @(posedge clk_i);
    end
  endtask

  // register write, only ever issued with the tracker idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SizeW-1:0] val);
    wait_idle(1'b1);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    apply_reg_write(idx, val);
    reg_writes++;
  endtask

  // resync drops, header bits, delta extremes, button edge and overflow drops
  task automatic test_directed_packets();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    // no sync bit while idle: both dropped
    send_byte(8'h00);
    send_byte(8'hF7);
    // zero move from reset position, sync-less delta bytes are fine inside a packet
    send_packet(8'h08, 8'h00, 8'h00);
    // left press with extreme deltas
    send_packet(8'h09, 8'h7F, 8'h80);
    // sign bits set in header but ignored, button still held so no click
    send_packet(8'h39, 8'h80, 8'h7F);
    // x overflow, y overflow, both overflow: all dropped
    send_packet(8'h48, 8'h7F, 8'h7F);
    send_packet(8'h89, 8'h80, 8'h80);
    send_packet(8'hFF, 8'hFF, 8'hFF);
    // release, then press again for a second click edge
    send_packet(8'h08, 8'hFF, 8'h01);
    send_byte(8'h0F);
    send_byte(8'h01);
    send_byte(8'hFE);
    wait_idle(1'b0);
  endtask

  // size registers: no upper clamp, largest size, tiny size, unknown indexes, mid-packet write
  task automatic test_register_writes();
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    // size 0 recentres to 0; push below zero, then up until the coordinate saturates
    write_reg(CfgScreenWidth, '0);
    write_reg(CfgScreenHeight, '0);
    send_packet(8'h08, 8'h80, 8'h7F);
    repeat (70) send_packet(8'h08, 8'h7F, 8'h80);
    // largest size: clamp at size - 1
    write_reg(CfgScreenWidth, SizeW'(CoordMax));
    write_reg(CfgScreenHeight, SizeW'(CoordMax));
    repeat (35) send_packet(8'h08, 8'h7F, 8'h80);
    repeat (3) send_packet(8'h09, 8'h80, 8'h7F);
    // size 1 pins both axes at 0
    write_reg(CfgScreenWidth, SizeW'(1));
    write_reg(CfgScreenHeight, SizeW'(1));
    send_packet(8'h08, 8'h7F, 8'h80);
    send_packet(8'h09, 8'h80, 8'h7F);
    // unmapped indexes must leave sizes and pointer alone
    write_reg(CfgNoReg2, SizeW'($urandom()));
    write_reg(CfgNoReg3, SizeW'(CoordMax));
    send_packet(8'h08, 8'h05, 8'hFB);
    // a write between bytes keeps the open packet open
    send_byte(8'h08);
    send_byte(8'h10);
    write_reg(CfgScreenWidth, SizeW'(ResetWidth));
    send_byte(8'hF0);
    send_byte(8'h09);
    write_reg(CfgScreenHeight, SizeW'(ResetHeight));
    send_byte(8'h20);
    send_byte(8'h20);
    wait_idle(1'b0);
  endtask

  function automatic logic [ByteW-1:0] pick_delta();
    logic [ByteW-1:0] edges[5] = '{8'h7F, 8'h80, 8'h00, 8'hFF, 8'h01};
    if ($urandom_range(0, 3) == 0) begin
      return edges[$urandom_range(0, 4)];
    end
    return ByteW'($urandom());
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return SizeW'(CoordMax);
      2:       return SizeW'($urandom_range(1, 16));
      default: return SizeW'($urandom_range(17, CoordMax));
    endcase
  endfunction

  // mostly well-formed packets with random content, plus noise, torn packets,
  // register writes, full drains and changes of idling behavior
  task automatic test_random_traffic();
    int               stop_at;
    int               kind;
    logic [ByteW-1:0] hdr;
    stop_at     = bytes_sent + RandomBytes;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        hdr = ByteW'($urandom()) | SyncMask;
        if ($urandom_range(0, 99) < 85) begin
          hdr = hdr & ~OvfMask;
        end
        send_packet(hdr, pick_delta(), pick_delta());
      end else if (kind < 90) begin
        send_byte(ByteW'($urandom()));
      end else if (kind < 93) begin
        // torn packet: the next header lands as this packet's last byte
        send_byte(ByteW'($urandom()) | SyncMask);
        send_byte(pick_delta());
      end else if (kind < 96) begin
        write_reg(CfgIdxW'($urandom_range(0, 3)), pick_size());
      end else if (kind < 98) begin
        // hold off until every position has come back
        wait_idle(1'b0);
      end else begin
        send_gaps   = $urandom_range(0, 1);
        recv_stalls = $urandom_range(0, 1);
      end
    end
  endtask

  initial begin : stimulus
    rst_ni           = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    width_q     = SizeW'(ResetWidth);
    height_q    = SizeW'(ResetHeight);
    pkt_bytes   = 0;
    hdr_q       = '0;
    dx_q        = '0;
    ptr_x_q     = CoordBits'(ResetX);
    ptr_y_q     = CoordBits'(ResetY);
    left_down_q = 1'b0;
    errors            = 0;
    bytes_sent        = 0;
    positions_checked = 0;
    clicks_seen       = 0;
    reg_writes        = 0;
    idle_cycles       = 0;
    send_gaps         = 1'b0;
    recv_stalls       = 1'b0;

    // reset held low at start, released away from the rising edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_directed_packets();
    test_register_writes();
    test_random_traffic();

    // drain, then give any stray output a chance to show up
    wait_idle(1'b1);

    $display("covered %0d bytes, %0d positions checked with %0d left-press edges,",
             bytes_sent, positions_checked, clicks_seen);
    $display("and %0d register writes across clamped, unclamped and pinned sizes",
             reg_writes);
    if (errors == 0) begin
      $display("tb_ps2_mouse_packet_tracker: PASS");
    end else begin
      $display("tb_ps2_mouse_packet_tracker: FAIL");
    end
    $finish;
  end

endmodule
